>>> src/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;
    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int TAB_WIDTH = 4;
    localparam int TAB_CW    = $clog2(TAB_WIDTH + 1);

    // scroll walk addresses exceed the cursor range
    localparam int WALK_W = 18;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] CFG_TEXT_COLOR   = 2'd0;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] CFG_LINE_COUNT   = 2'd2;
    localparam logic [1:0] CFG_LINE_STRIDE  = 2'd3;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [13:0] {
        S_CLEAR    = 14'b00000000000001,
        S_IDLE     = 14'b00000000000010,
        S_CHK      = 14'b00000000000100,
        S_CHKW     = 14'b00000000001000,
        S_SCR_RD   = 14'b00000000010000,
        S_SCR_WR   = 14'b00000000100000,
        S_SCR_ZERO = 14'b00000001000000,
        S_SCR_DIV  = 14'b00000010000000,
        S_SCR_DIVW = 14'b00000100000000,
        S_ACT      = 14'b00001000000000,
        S_COLOR    = 14'b00010000000000,
        S_NEXT     = 14'b00100000000000,
        S_FIN      = 14'b01000000000000,
        S_FINW     = 14'b10000000000000
    } t_state;
endpackage

>>> src/tcw_ram.sv
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/tcw_div.sv
`timescale 1ns / 1ps
module tcw_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [8:0]  i_divisor,
    output logic        o_busy,
    output logic [15:0] o_quotient,
    output logic [8:0]  o_remainder
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_quo;
    logic [8:0]  r_rem;
    logic [8:0]  r_dvs;
    logic [9:0]  n_shift;
    logic [10:0] n_trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_shift = {r_rem, r_quo[15]};
        n_trial = {1'b0, n_shift} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
            r_quo  <= i_dividend;
            r_rem  <= 9'd0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (n_trial[10]) begin
                r_rem <= n_shift[8:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end else begin
                r_rem <= n_trial[8:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

>>> src/text_console_char_writer.sv
`timescale 1ns / 1ps
// text console character writer
// input channel (i_in_valid / o_in_ready) carries one command: put a character
// (i_cmd 0, i_char_code) or read one screen byte (i_cmd 1, i_read_address).
// each command returns one result on the output channel (o_out_valid /
// i_out_ready): the byte read (zero for puts) and the cursor line and column.
// the config channel writes text_color, column_count, line_count, line_stride
// by index; it is always ready. the user must write it only while the block is
// idle; the block itself does not enforce this. one command at a time; the
// cursor split by the line stride goes through a single shared serial
// divider, so a read needs one divide and a plain put two (one divide for the
// scroll check, one for the result). a tab runs four puts. a scroll reads and
// writes each byte in turn to copy the lines up, then zeroes the last line.
// reset clears the cursor, loads the default registers and then sweeps the
// screen RAM to zero, one byte a cycle for all 4096 bytes, with o_in_ready low.
// a finished result waits in the output register while the receiver stalls;
// the next command is taken meanwhile and holds in its last step until the
// output register is free.
module text_console_char_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [11:0] i_read_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_cursor_line,
    output logic [7:0]  o_cursor_column,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import tcw_pkg::*;

    t_state r_state;
    logic [7:0]  r_color, r_cols, r_lines;
    logic [8:0]  r_stride;
    logic [15:0] r_cursor;
    logic [MEM_AW-1:0] r_clr;
    logic        r_cmd, r_oob;
    logic [7:0]  r_ch;
    logic [TAB_CW-1:0] r_tab;
    logic [8:0]  r_rem;
    logic [WALK_W-1:0] r_dst;
    logic [8:0]  r_k;
    logic [7:0]  r_ln;
    logic        r_out_valid;
    logic [7:0]  r_out_data, r_out_line, r_out_col;

    logic [8:0]  s_eff;
    logic [8:0]  width;
    logic [WALK_W-1:0] src_addr, dst_addr, cur_addr;
    logic        div_start, div_busy;
    logic [15:0] div_quo;
    logic [8:0]  div_rem;
    logic        ram_we, ram_re;
    logic [MEM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic        out_free;
    logic [WALK_W-1:0] rd_full;

    // effective stride and line width in bytes
    assign s_eff    = (r_stride < 9'd2) ? 9'd2 : r_stride;
    assign width    = {r_cols, 1'b0};
    assign src_addr = r_dst + WALK_W'(s_eff) + WALK_W'(r_k);
    assign dst_addr = r_dst + WALK_W'(r_k);
    assign cur_addr = WALK_W'(r_cursor);
    assign rd_full  = WALK_W'(i_read_address);
    assign out_free = !r_out_valid || i_out_ready;

    assign div_start = (r_state == S_CHK) || (r_state == S_SCR_DIV) || (r_state == S_FIN);

    tcw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_cursor),
        .i_divisor   (s_eff),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    tcw_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // screen RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 8'd0;
        ram_re    = 1'b0;
        ram_raddr = src_addr[MEM_AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_re    = i_in_valid && (i_cmd == CMD_READ);
                ram_raddr = rd_full[MEM_AW-1:0];
            end
            S_SCR_RD: begin
                ram_re = (r_k != width) && (src_addr < WALK_W'(MEM_BYTES));
            end
            S_SCR_WR: begin
                ram_we    = dst_addr < WALK_W'(MEM_BYTES);
                ram_waddr = dst_addr[MEM_AW-1:0];
                ram_wdata = r_oob ? 8'd0 : ram_rdata;
            end
            S_SCR_ZERO: begin
                ram_we    = (r_k != width) && (dst_addr < WALK_W'(MEM_BYTES));
                ram_waddr = dst_addr[MEM_AW-1:0];
            end
            S_ACT: begin
                ram_we    = (r_ch != CH_CR) && (r_ch != CH_LF) && (r_ch != CH_BS)
                            && (cur_addr < WALK_W'(MEM_BYTES));
                ram_waddr = cur_addr[MEM_AW-1:0];
                ram_wdata = r_ch;
            end
            S_COLOR: begin
                ram_we    = cur_addr < WALK_W'(MEM_BYTES);
                ram_waddr = cur_addr[MEM_AW-1:0];
                ram_wdata = r_color;
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= 8'd7;
            r_cols   <= 8'd80;
            r_lines  <= 8'd25;
            r_stride <= 9'd160;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEXT_COLOR:   r_color  <= i_cfg_data[7:0];
                CFG_COLUMN_COUNT: r_cols   <= i_cfg_data[7:0];
                CFG_LINE_COUNT:   r_lines  <= i_cfg_data[7:0];
                CFG_LINE_STRIDE:  r_stride <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cursor    <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            // result transfer frees the output register unless a new result lands
            if (r_out_valid && i_out_ready && !((r_state == S_FINW) && !div_busy)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MEM_AW'(1);
                    if (r_clr == MEM_AW'(MEM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd <= i_cmd;
                        r_oob <= rd_full >= WALK_W'(MEM_BYTES);
                        r_ch  <= (i_char_code == CH_TAB) ? CH_SPACE : i_char_code;
                        r_tab <= (i_char_code == CH_TAB) ? TAB_CW'(TAB_WIDTH) : TAB_CW'(1);
                        if (i_cmd == CMD_READ || r_lines == 8'd0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_state <= S_CHKW;
                end
                S_CHKW: begin
                    if (!div_busy) begin
                        r_rem <= div_rem;
                        r_dst <= '0;
                        r_k   <= 9'd0;
                        r_ln  <= 8'd0;
                        if (div_quo < {8'd0, r_lines}) begin
                            r_state <= S_ACT;
                        end else if (r_lines == 8'd1) begin
                            r_state <= S_SCR_ZERO;
                        end else begin
                            r_state <= S_SCR_RD;
                        end
                    end
                end
                S_SCR_RD: begin
                    if (r_k == width) begin
                        r_k   <= 9'd0;
                        r_dst <= r_dst + WALK_W'(s_eff);
                        r_ln  <= r_ln + 8'd1;
                        if (r_ln + 8'd1 == r_lines - 8'd1) begin
                            r_state <= S_SCR_ZERO;
                        end
                    end else begin
                        r_oob   <= src_addr >= WALK_W'(MEM_BYTES);
                        r_state <= S_SCR_WR;
                    end
                end
                S_SCR_WR: begin
                    r_k     <= r_k + 9'd1;
                    r_state <= S_SCR_RD;
                end
                S_SCR_ZERO: begin
                    if (r_k == width) begin
                        r_cursor <= r_dst[15:0] + {7'd0, r_rem};
                        r_state  <= S_SCR_DIV;
                    end else begin
                        r_k <= r_k + 9'd1;
                    end
                end
                S_SCR_DIV: begin
                    r_state <= S_SCR_DIVW;
                end
                S_SCR_DIVW: begin
                    if (!div_busy) begin
                        if (r_cols != 8'd0) begin
                            r_cursor <= r_cursor - {7'd0, div_rem};
                            r_rem    <= 9'd0;
                        end else begin
                            r_rem <= div_rem;
                        end
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    case (r_ch)
                        CH_CR: begin
                            if (r_cols != 8'd0) begin
                                r_cursor <= r_cursor - {7'd0, r_rem};
                            end
                            r_state <= S_NEXT;
                        end
                        CH_LF: begin
                            r_cursor <= r_cursor + {7'd0, s_eff};
                            r_state  <= S_NEXT;
                        end
                        CH_BS: begin
                            if (r_cursor >= 16'd2) begin
                                r_cursor <= r_cursor - 16'd2;
                            end
                            r_state <= S_NEXT;
                        end
                        default: begin
                            r_cursor <= r_cursor + 16'd1;
                            r_state  <= S_COLOR;
                        end
                    endcase
                end
                S_COLOR: begin
                    r_cursor <= r_cursor + 16'd1;
                    r_state  <= S_NEXT;
                end
                S_NEXT: begin
                    r_tab <= r_tab - TAB_CW'(1);
                    if (r_tab == TAB_CW'(1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_FIN: begin
                    r_state <= S_FINW;
                end
                S_FINW: begin
                    if (!div_busy && out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= (r_cmd == CMD_READ && !r_oob) ? ram_rdata : 8'd0;
                        r_out_line  <= div_quo[7:0];
                        r_out_col   <= div_rem[8:1];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_cursor_line   = r_out_line;
    assign o_cursor_column = r_out_col;
endmodule

>>> src/tcw_chk.sv
`timescale 1ns / 1ps
module tcw_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_data,
    input logic [7:0] o_cursor_line,
    input logic [7:0] o_cursor_column
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_cursor_line) && $stable(o_cursor_column))
        else $error("stalled result changed");

    // a transfer in makes the block busy
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready after input transfer");

    // reset empties the output and starts the clearing sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("not quiet after reset");
endmodule

bind text_console_char_writer tcw_chk u_tcw_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_read_data     (o_read_data),
    .o_cursor_line   (o_cursor_line),
    .o_cursor_column (o_cursor_column)
);

>>> sim/text_console_char_writer_tb.sv
`timescale 1ns / 1ps
module text_console_char_writer_tb;
    import tcw_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] line;
        logic [7:0] column;
    } t_console_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = CMD_PUT;
    logic [7:0]  i_char_code = 8'h00;
    logic [11:0] i_read_address = 12'h000;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic [7:0]  o_cursor_line;
    logic [7:0]  o_cursor_column;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_TEXT_COLOR;
    logic [8:0]  i_cfg_data = 9'd0;

    text_console_char_writer DUT (.*);

    always #10 i_clk = ~i_clk;

    // shadow of the screen, cursor and registers
    logic [7:0]  shadow_screen [MEM_BYTES];
    logic [15:0] cursor;
    logic [7:0]  text_color   = 8'd7;
    logic [7:0]  column_count = 8'd80;
    logic [7:0]  line_count   = 8'd25;
    logic [8:0]  line_stride  = 9'd160;

    t_console_result expected_results[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_scrolls = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_go = 0;
    int hold_left = 0;

    function automatic int stride_now();
        return (line_stride < 2) ? 2 : int'(line_stride);
    endfunction

    function automatic logic [7:0] screen_rd(int addr);
        return (addr < MEM_BYTES) ? shadow_screen[addr] : 8'h00;
    endfunction

    function automatic void screen_wr(int addr, logic [7:0] v);
        if (addr < MEM_BYTES) shadow_screen[addr] = v;
    endfunction

    function automatic void cursor_to_line(int ln);
        int s;
        s = stride_now();
        cursor = 16'(ln * s + int'(cursor) % s);
    endfunction

    function automatic void cursor_to_col0();
        int s;
        s = stride_now();
        if (column_count == 0) return;
        cursor = 16'(int'(cursor) - int'(cursor) % s);
    endfunction

    function automatic void scroll_check();
        int s;
        int w;
        int dst;
        s = stride_now();
        w = int'(column_count) * 2;
        dst = 0;
        if (int'(cursor) / s < int'(line_count)) return;
        n_scrolls++;
        for (int i = 0; i + 1 < int'(line_count); i++) begin
            for (int k = 0; k < w; k++) screen_wr(dst + k, screen_rd(dst + s + k));
            dst += s;
        end
        for (int k = 0; k < w; k++) screen_wr(dst + k, 8'h00);
        cursor_to_line(int'(line_count) - 1);
        cursor_to_col0();
    endfunction

    function automatic void put_glyph(logic [7:0] c);
        if (line_count == 0) return;
        scroll_check();
        case (c)
            CH_CR: cursor_to_col0();
            CH_LF: cursor_to_line(int'(cursor) / stride_now() + 1);
            CH_TAB: for (int i = 0; i < TAB_WIDTH; i++) put_glyph(CH_SPACE);
            CH_BS: if (cursor >= 2) cursor = cursor - 16'd2;
            default: begin
                screen_wr(int'(cursor), c);
                cursor = cursor + 16'd1;
                screen_wr(int'(cursor), text_color);
                cursor = cursor + 16'd1;
            end
        endcase
    endfunction

    // predicted result for one accepted command
    function automatic t_console_result console_predict(logic cmd, logic [7:0] ch,
                                                        logic [11:0] addr);
        t_console_result r;
        int s;
        r.read_data = 8'h00;
        if (cmd == CMD_READ) r.read_data = screen_rd(int'(addr));
        else put_glyph(ch);
        s = stride_now();
        r.line   = 8'(int'(cursor) / s);
        r.column = 8'((int'(cursor) % s) >> 1);
        return r;
    endfunction

    // receiver ready, with random stalls and a counted hold-off
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_left <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: actual %h %h %h", $time,
                         o_read_data, o_cursor_line, o_cursor_column);
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    errors++;
                    $display("%0t read_data expected %h actual %h", $time,
                             want.read_data, o_read_data);
                end
                if (o_cursor_line !== want.line) begin
                    errors++;
                    $display("%0t cursor_line expected %h actual %h", $time,
                             want.line, o_cursor_line);
                end
                if (o_cursor_column !== want.column) begin
                    errors++;
                    $display("%0t cursor_column expected %h actual %h", $time,
                             want.column, o_cursor_column);
                end
            end
        end
    end

    // one command transfer; valid stays up when the next one follows at once
    task automatic send_cmd(input logic cmd, input logic [7:0] ch, input logic [11:0] addr);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_char_code <= ch;
        i_read_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        expected_results.push_back(console_predict(cmd, ch, addr));
    endtask

    task automatic put(input logic [7:0] ch);
        send_cmd(CMD_PUT, ch, 12'($urandom));
    endtask

    task automatic peek(input logic [11:0] addr);
        send_cmd(CMD_READ, 8'($urandom), addr);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 9'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TEXT_COLOR:   text_color = 8'(val);
            CFG_COLUMN_COUNT: column_count = 8'(val);
            CFG_LINE_COUNT:   line_count = 8'(val);
            default:          line_stride = 9'(val);
        endcase
    endtask

    task automatic set_screen(input int color, input int cols, input int lines,
                              input int stride);
        write_reg(CFG_TEXT_COLOR, color);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_LINE_COUNT, lines);
        write_reg(CFG_LINE_STRIDE, stride);
    endtask

    task automatic test_defaults();
        peek(12'h000);
        peek(12'hFFF);
        put(8'h41);
        peek(12'h000);
        peek(12'h001);
        put(8'h00);
        put(8'hFF);
        peek(12'h003);
    endtask

    task automatic test_control_codes();
        put(CH_CR);
        put(CH_TAB);
        put(CH_LF);
        put(CH_BS);
        put(CH_CR);
        put(CH_BS);
        put(CH_BS);
        put(8'h0B);
        put(8'h0C);
        peek(12'h0A0);
        peek(12'h0A9);
    endtask

    // fill the default screen to force scrolls
    task automatic test_scroll_default();
        for (int i = 0; i < 27; i++) begin
            put(8'h30 + 8'(i % 10));
            put(CH_LF);
        end
        peek(12'h000);
        peek(12'h0A0);
        peek(12'(24 * 160));
    endtask

    task automatic test_register_extremes();
        // zero columns: carriage return ignored, scroll keeps the column
        set_screen(255, 0, 2, 2);
        put(8'h55);
        put(CH_CR);
        put(CH_LF);
        put(CH_LF);
        put(8'h66);
        peek(12'h000);
        // zero lines: puts change nothing
        set_screen(0, 5, 0, 10);
        put(8'h21);
        put(CH_LF);
        peek(12'h000);
        // widest line with a scroll
        set_screen(8'h5A, 255, 2, 510);
        repeat (3) put(CH_LF);
        put(8'h7E);
        peek(12'h1FE);
        // tall screen: cursor runs past the store and wraps
        set_screen(8'hA5, 255, 255, 510);
        repeat (130) put(CH_LF);
        put(8'h2A);
        put(CH_TAB);
        peek(12'hFFF);
        // odd stride
        set_screen(8'h13, 3, 4, 257);
        repeat (5) put(CH_LF);
        put(8'h3F);
    endtask

    function automatic logic [7:0] random_glyph();
        int r;
        r = $urandom_range(99);
        if (r < 12) return CH_LF;
        if (r < 20) return CH_CR;
        if (r < 25) return CH_TAB;
        if (r < 33) return CH_BS;
        return 8'($urandom);
    endfunction

    task automatic random_config();
        int cols;
        int lines;
        int stride;
        cols = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
        lines = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 8);
        stride = ($urandom_range(1) == 0) ? $urandom_range(2, 510)
                                          : $urandom_range(2, 2 * cols + 20);
        set_screen($urandom_range(255), cols, lines, stride);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        stall_pct = stall;
        random_config();
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 99) random_config();
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(4) == 0) peek(12'($urandom));
                else peek(12'($urandom_range(0, int'(line_count) * stride_now() + 2)));
            end else begin
                put(random_glyph());
            end
        end
    endtask

    // long receiver hold-off while commands keep coming, then a full pause
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        set_screen(8'h1E, 10, 4, 24);
        hold_go = 1;
        for (int i = 0; i < 40; i++) put(random_glyph());
        drain();
        for (int i = 0; i < 10; i++) put(8'($urandom));
        drain();
    endtask

    initial begin
        for (int i = 0; i < MEM_BYTES; i++) shadow_screen[i] = 8'h00;
        cursor = 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_control_codes();
        test_scroll_default();
        test_register_extremes();
        test_backpressure();
        test_random_phase(0, 0, 420);
        test_random_phase(59, 0, 420);
        test_random_phase(0, 59, 420);
        test_random_phase(33, 33, 420);
        drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d commands, %0d results, %0d scrolls across random screen shapes",
                 n_items, n_results, n_scrolls);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("text_console_char_writer: match");
        end else begin
            $display("%0d errors, %0d results missing", errors, expected_results.size());
            $display("text_console_char_writer: mismatch");
        end
        $finish;
    end

    // run time limit
    initial begin
        #200ms;
        $display("timeout");
        $display("text_console_char_writer: mismatch");
        $finish;
    end
endmodule

>>> text_console_char_writer.f
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_div.sv
src/text_console_char_writer.sv
src/tcw_chk.sv
sim/text_console_char_writer_tb.sv
